/* hw/rtl/btgl_pkg.sv */
// Package for the bitmap text glyph layout block.
// Holds the glyph width ROM, character codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
package btgl_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   // Character codes with a special meaning.
   localparam logic [7:0] CODE_TAB      = 8'h09;
   localparam logic [7:0] CODE_NEWLINE  = 8'h0a;
   localparam logic [7:0] CODE_SPACE    = 8'h20;
   localparam logic [7:0] CODE_FIRST    = 8'h21;
   localparam logic [7:0] CODE_INVALID  = 8'h7f;
   localparam logic [7:0] CODE_PAST_END = 8'h89;

   localparam int GLYPH_COUNT = 104;
   localparam int GRID_COUNT  = 95;

   // Configuration register indexes.
   localparam logic [2:0] REG_DRAW_MODE   = 3'd0;
   localparam logic [2:0] REG_SCALE       = 3'd1;
   localparam logic [2:0] REG_ATLAS_U     = 3'd2;
   localparam logic [2:0] REG_ATLAS_V     = 3'd3;
   localparam logic [2:0] REG_TAB_WIDTH   = 3'd4;
   localparam logic [2:0] REG_LINE_HEIGHT = 3'd5;
   localparam logic [2:0] REG_SPACE_WIDTH = 3'd6;

   localparam logic [9:0] SCALE_RESET    = 10'd100;
   localparam logic [7:0] TAB_RESET      = 8'd32;
   localparam logic [7:0] LINE_RESET     = 8'd10;
   localparam logic [7:0] SPACE_RESET    = 8'd4;
   localparam logic [6:0] PERCENT_DIV    = 7'd100;
   localparam logic [6:0] PERCENT_ROUND  = 7'd50;

   typedef logic [3:0] glyph_w_type [0:GLYPH_COUNT-1];

   localparam glyph_w_type GLYPH_W = '{
      4'd2, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd2, 4'd3, 4'd3, 4'd4, 4'd6, 4'd3, 4'd6, 4'd2, 4'd6,
      4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
      4'd2, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
      4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
      4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
      4'd3, 4'd6, 4'd3, 4'd4, 4'd6, 4'd3,
      4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd5, 4'd2, 4'd4, 4'd5, 4'd2, 4'd6, 4'd5, 4'd6,
      4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5,
      4'd4, 4'd2, 4'd4, 4'd6, 4'd6,
      4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd7, 4'd7
   };

   function automatic logic [3:0] glyph_width(input logic [6:0] idx);
      return GLYPH_W[idx];
   endfunction

endpackage

/* hw/rtl/bitmap_text_glyph_layout.sv */
// Top level of the bitmap text glyph layout block.
// Depends on btgl_pkg; holds the sequencer and the shared multiply/divide unit.
`timescale 1ns / 1ps
// One character word goes in, one result word comes out. Every scaling goes through one
// shared multiplier followed by a reciprocal multiply for the division by 100. The tab
// stop and tab measurement modulos run through one radix-2 restoring divider that
// retires one quotient bit per cycle over a DW = max(COORD_BITS, 26) bit dividend.
// A rectangle-mode glyph, space or newline needs no scaling. A quad-mode glyph takes
// two scalings; a quad-mode space or newline takes one. A tab takes one division for
// the position and one for the measured width, plus one scaling in quad mode. The
// last word of a string in quad mode adds one scaling for the width report. A new
// word is taken only once the previous one is finished; a finished result waits in
// the output register while the next word is already being laid out.
module bitmap_text_glyph_layout
   import btgl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // char_code[7:0], start_x[23:8], start_y[39:24]
   input  logic        req_tuser,   // first_of_string
   input  logic        req_tlast,   // last_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // screen_x[15:0], screen_y[31:16], tex_u[39:32], tex_v[47:40], source_width[51:48],
   // source_height[55:52], drawn_width[62:56], drawn_height[69:63],
   // semi_transparent[70], measured_width[86:71], zero[87]
   output logic [87:0] rsp_tdata,
   output logic        rsp_tuser,   // glyph_valid
   output logic        rsp_tlast,   // width_valid
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CB = COORD_BITS;
   localparam int DW = (COORD_BITS > 26) ? COORD_BITS : 26;
   localparam int CNTW = $clog2(DW + 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_FIRST  = 4'd1;
   localparam logic [3:0] ST_DECODE = 4'd2;
   localparam logic [3:0] ST_MUL    = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_POST   = 4'd5;
   localparam logic [3:0] ST_APPLY  = 4'd6;
   localparam logic [3:0] ST_REPORT = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;
   localparam logic [3:0] ST_RECIP  = 4'd9;

   localparam logic [2:0] JOB_SW = 3'd0;
   localparam logic [2:0] JOB_SH = 3'd1;
   localparam logic [2:0] JOB_ST = 3'd2;
   localparam logic [2:0] JOB_TP = 3'd3;
   localparam logic [2:0] JOB_TM = 3'd4;
   localparam logic [2:0] JOB_SL = 3'd5;
   localparam logic [2:0] JOB_SP = 3'd6;
   localparam logic [2:0] JOB_SR = 3'd7;

   localparam logic [1:0] KIND_GLYPH = 2'd0;
   localparam logic [1:0] KIND_TAB   = 2'd1;
   localparam logic [1:0] KIND_NL    = 2'd2;
   localparam logic [1:0] KIND_SPACE = 2'd3;

   // ceil(2^33 / 100): the product shifted right by 33 is the exact quotient by 100
   // for any dividend below 2^30, and scaling dividends stay below 2^26.
   localparam logic [26:0] RECIP_100 = 27'd85899346;

   // Configuration registers.
   logic       mode_ff;
   logic [9:0] scale_ff;
   logic [7:0] atlas_u_ff, atlas_v_ff, tab_w_ff, line_h_ff, space_w_ff;

   // Layout state.
   logic [CB-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in, org_x_ff, org_x_in;
   logic [15:0]   meas_x_ff, meas_x_in, meas_max_ff, meas_max_in;

   // Sequencer and item registers.
   logic [3:0]    state_ff, state_in;
   logic [2:0]    job_ff, job_in;
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    code_ff, code_in;
   logic          first_ff, first_in, last_ff, last_in;
   logic [15:0]   sx_ff, sx_in, sy_ff, sy_in;
   logic [7:0]    ch_ff, ch_in;
   logic [3:0]    w_ff, w_in, h_ff, h_in;
   logic [6:0]    dw_ff, dw_in, dh_ff, dh_in;
   logic [11:0]   adv_ff, adv_in;
   logic [CB-1:0] s_ff, s_in, tabx_ff, tabx_in;
   logic          neg_ff, neg_in;
   logic [16:0]   m_ff, m_in;
   logic [15:0]   measn_ff, measn_in, rep_ff, rep_in;
   logic [15:0]   res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [7:0]    res_u_ff, res_u_in, res_v_ff, res_v_in;

   // Shared divider.
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [11:0]   rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   // Output register.
   logic          out_v_ff, out_v_in;
   logic [87:0]   out_d_ff, out_d_in;
   logic          out_u_ff, out_u_in, out_l_ff, out_l_in;

   logic          cfg_wr;
   logic [7:0]    tab_n;
   logic [6:0]    idx;
   logic [7:0]    gx, gy;
   logic [15:0]   scale_n;
   logic [25:0]   prod;
   logic [52:0]   recip;
   logic [12:0]   trial;
   logic [CB-1:0] mag, s_calc;
   logic [11:0]   rfl;
   logic [16:0]   sum17, msub;
   logic [15:0]   mmax;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_u_ff;
   assign rsp_tlast  = out_l_ff;
   assign tab_n = (tab_w_ff == 8'd0) ? 8'd1 : tab_w_ff;
   assign mmax = (meas_x_ff > meas_max_ff) ? meas_x_ff : meas_max_ff;

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_DRAW_MODE:   csr_prdata = {31'd0, mode_ff};
         REG_SCALE:       csr_prdata = {22'd0, scale_ff};
         REG_ATLAS_U:     csr_prdata = {24'd0, atlas_u_ff};
         REG_ATLAS_V:     csr_prdata = {24'd0, atlas_v_ff};
         REG_TAB_WIDTH:   csr_prdata = {24'd0, tab_w_ff};
         REG_LINE_HEIGHT: csr_prdata = {24'd0, line_h_ff};
         REG_SPACE_WIDTH: csr_prdata = {24'd0, space_w_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         scale_ff   <= SCALE_RESET;
         atlas_u_ff <= 8'd0;
         atlas_v_ff <= 8'd0;
         tab_w_ff   <= TAB_RESET;
         line_h_ff  <= LINE_RESET;
         space_w_ff <= SPACE_RESET;
      end else if (cfg_wr) begin
         unique case (csr_paddr[4:2])
            REG_DRAW_MODE:   mode_ff    <= csr_pwdata[0];
            REG_SCALE:       scale_ff   <= csr_pwdata[9:0];
            REG_ATLAS_U:     atlas_u_ff <= csr_pwdata[7:0];
            REG_ATLAS_V:     atlas_v_ff <= csr_pwdata[7:0];
            REG_TAB_WIDTH:   tab_w_ff   <= csr_pwdata[7:0];
            REG_LINE_HEIGHT: line_h_ff  <= csr_pwdata[7:0];
            REG_SPACE_WIDTH: space_w_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Glyph cell position in the atlas.
   assign idx = 7'(ch_ff - CODE_FIRST);
   always_comb begin
      if (idx < 7'(GRID_COUNT)) begin
         gx = 8'(8'({4'd0, 4'(idx + 7'd1)}) * 8'd6);
         gy = 8'(8'(3'((idx + 7'd1) >> 4)) * 8'd9);
      end else begin
         gx = 8'(8'(idx - 7'(GRID_COUNT)) * 8'd10);
         gy = 8'd54;
      end
   end

   always_comb begin
      unique case (job_ff)
         JOB_SW:  scale_n = {12'd0, w_ff};
         JOB_SH:  scale_n = {12'd0, h_ff};
         JOB_ST:  scale_n = {8'd0, tab_w_ff};
         JOB_SL:  scale_n = {8'd0, line_h_ff};
         JOB_SP:  scale_n = {8'd0, space_w_ff};
         default: scale_n = rep_ff;
      endcase
   end
   assign prod   = 26'(scale_n) * 26'(scale_ff);
   assign recip  = 53'(dvd_ff[25:0]) * 53'(RECIP_100);
   assign s_calc = cur_x_ff + CB'(adv_ff) - CB'(1);
   assign mag    = s_calc[CB-1] ? (~s_calc + CB'(1)) : s_calc;
   assign trial  = {rem_ff, dvd_ff[DW-1]};
   assign rfl    = (neg_ff && rem_ff != 12'd0) ? (adv_ff - rem_ff) : rem_ff;
   assign msub   = m_ff - 17'(rem_ff);

   always_comb begin
      state_in = state_ff;  job_in = job_ff;  kind_in = kind_ff;
      code_in = code_ff;  first_in = first_ff;  last_in = last_ff;
      sx_in = sx_ff;  sy_in = sy_ff;  ch_in = ch_ff;
      w_in = w_ff;  h_in = h_ff;  dw_in = dw_ff;  dh_in = dh_ff;
      adv_in = adv_ff;  s_in = s_ff;  neg_in = neg_ff;  tabx_in = tabx_ff;
      m_in = m_ff;  measn_in = measn_ff;  rep_in = rep_ff;
      res_x_in = res_x_ff;  res_y_in = res_y_ff;  res_u_in = res_u_ff;  res_v_in = res_v_ff;
      dvd_in = dvd_ff;  rem_in = rem_ff;  dvs_in = dvs_ff;  cnt_in = cnt_ff;
      cur_x_in = cur_x_ff;  cur_y_in = cur_y_ff;  org_x_in = org_x_ff;
      meas_x_in = meas_x_ff;  meas_max_in = meas_max_ff;
      out_v_in = out_v_ff;  out_d_in = out_d_ff;  out_u_in = out_u_ff;  out_l_in = out_l_ff;
      sum17 = 17'd0;

      if (out_v_ff && rsp_tready) out_v_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               code_in  = req_tdata[7:0];
               sx_in    = req_tdata[23:8];
               sy_in    = req_tdata[39:24];
               first_in = req_tuser;
               last_in  = req_tlast;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (first_ff) begin
               cur_x_in    = CB'($signed(sx_ff));
               cur_y_in    = CB'($signed(sy_ff));
               org_x_in    = CB'($signed(sx_ff));
               meas_x_in   = 16'd0;
               meas_max_in = 16'd0;
            end
            // Codes outside the ROM, and control codes, draw the invalid glyph.
            ch_in = (code_ff >= CODE_PAST_END || code_ff < CODE_FIRST) ? CODE_INVALID
                                                                       : code_ff;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            res_x_in = 16'($signed(cur_x_ff));
            res_y_in = 16'($signed(cur_y_ff));
            res_u_in = atlas_u_ff + gx;
            res_v_in = atlas_v_ff + gy;
            w_in = glyph_width(idx);
            h_in = (idx < 7'(GRID_COUNT)) ? 4'd9 : 4'd10;
            dw_in = 7'(glyph_width(idx));
            dh_in = (idx < 7'(GRID_COUNT)) ? 7'd9 : 7'd10;
            state_in = mode_ff ? ST_MUL : ST_APPLY;
            if (code_ff == CODE_TAB) begin
               kind_in = KIND_TAB;
               adv_in = {4'd0, tab_n};
               job_in = mode_ff ? JOB_ST : JOB_TP;
               state_in = ST_MUL;
            end else if (code_ff == CODE_NEWLINE) begin
               kind_in = KIND_NL;
               adv_in = {4'd0, line_h_ff};
               job_in = JOB_SL;
            end else if (code_ff == CODE_SPACE) begin
               kind_in = KIND_SPACE;
               adv_in = {4'd0, space_w_ff};
               job_in = JOB_SP;
            end else begin
               kind_in = KIND_GLYPH;
               job_in = JOB_SW;
            end
         end
         ST_MUL: begin
            // Load the shared divider; scaling jobs instead load the product and take the reciprocal multiply.
            rem_in = 12'd0;
            cnt_in = CNTW'(DW);
            state_in = ST_DIV;
            unique case (job_ff)
               JOB_TP: begin
                  s_in   = s_calc;
                  neg_in = s_calc[CB-1];
                  dvd_in = DW'(mag);
                  dvs_in = adv_ff;
               end
               JOB_TM: begin
                  m_in   = 17'(meas_x_ff) + 17'(tab_n) - 17'd1;
                  dvd_in = DW'(17'(meas_x_ff) + 17'(tab_n) - 17'd1);
                  dvs_in = {4'd0, tab_n};
               end
               default: begin
                  dvd_in = DW'(prod + 26'(PERCENT_ROUND));
                  state_in = ST_RECIP;
               end
            endcase
         end
         ST_RECIP: begin
            dvd_in = DW'(recip[52:33]);
            state_in = ST_POST;
         end
         ST_DIV: begin
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in = 12'(trial - {1'b0, dvs_ff});
               dvd_in = {dvd_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = trial[11:0];
               dvd_in = {dvd_ff[DW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) state_in = ST_POST;
         end
         ST_POST: begin
            unique case (job_ff)
               JOB_SW: begin
                  dw_in = (dvd_ff == '0) ? 7'd1 : dvd_ff[6:0];
                  job_in = JOB_SH;
                  state_in = ST_MUL;
               end
               JOB_SH: begin
                  dh_in = (dvd_ff == '0) ? 7'd1 : dvd_ff[6:0];
                  state_in = ST_APPLY;
               end
               JOB_ST: begin
                  adv_in = (dvd_ff == '0) ? 12'd1 : dvd_ff[11:0];
                  job_in = JOB_TP;
                  state_in = ST_MUL;
               end
               JOB_TP: begin
                  // Floor modulo: negative positions land on absolute stops too.
                  tabx_in = s_ff - CB'(rfl);
                  job_in = JOB_TM;
                  state_in = ST_MUL;
               end
               JOB_TM: begin
                  measn_in = msub[16] ? 16'hffff : msub[15:0];
                  state_in = ST_APPLY;
               end
               JOB_SL, JOB_SP: begin
                  adv_in = dvd_ff[11:0];
                  state_in = ST_APPLY;
               end
               default: begin
                  rep_in = (|dvd_ff[DW-1:16]) ? 16'hffff : dvd_ff[15:0];
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_APPLY: begin
            unique case (kind_ff)
               KIND_TAB: begin
                  cur_x_in  = tabx_ff;
                  meas_x_in = measn_ff;
               end
               KIND_NL: begin
                  cur_x_in = org_x_ff;
                  cur_y_in = cur_y_ff + CB'(adv_ff);
                  meas_max_in = mmax;
                  meas_x_in = 16'd0;
               end
               KIND_SPACE: begin
                  cur_x_in = cur_x_ff + CB'(adv_ff);
                  sum17 = 17'(meas_x_ff) + 17'(space_w_ff);
                  meas_x_in = sum17[16] ? 16'hffff : sum17[15:0];
               end
               default: begin
                  cur_x_in = cur_x_ff + CB'(dw_ff);
                  sum17 = 17'(meas_x_ff) + 17'(w_ff);
                  meas_x_in = sum17[16] ? 16'hffff : sum17[15:0];
               end
            endcase
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            rep_in = mmax;
            if (last_ff && mode_ff) begin
               job_in = JOB_SR;
               state_in = ST_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_v_ff || rsp_tready) begin
               out_v_in = 1'b1;
               out_u_in = (kind_ff == KIND_GLYPH);
               out_l_in = last_ff;
               out_d_in = '0;
               if (kind_ff == KIND_GLYPH) begin
                  out_d_in[15:0]  = res_x_ff;
                  out_d_in[31:16] = res_y_ff;
                  out_d_in[39:32] = res_u_ff;
                  out_d_in[47:40] = res_v_ff;
                  out_d_in[51:48] = w_ff;
                  out_d_in[55:52] = h_ff;
                  out_d_in[62:56] = dw_ff;
                  out_d_in[69:63] = dh_ff;
                  out_d_in[70]    = !mode_ff && ch_ff[7];
               end
               if (last_ff) out_d_in[86:71] = rep_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_v_ff    <= 1'b0;
         cur_x_ff    <= '0;
         cur_y_ff    <= '0;
         org_x_ff    <= '0;
         meas_x_ff   <= 16'd0;
         meas_max_ff <= 16'd0;
      end else begin
         state_ff    <= state_in;
         out_v_ff    <= out_v_in;
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         org_x_ff    <= org_x_in;
         meas_x_ff   <= meas_x_in;
         meas_max_ff <= meas_max_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;  kind_ff <= kind_in;  code_ff <= code_in;
      first_ff <= first_in;  last_ff <= last_in;  sx_ff <= sx_in;  sy_ff <= sy_in;
      ch_ff <= ch_in;  w_ff <= w_in;  h_ff <= h_in;  dw_ff <= dw_in;  dh_ff <= dh_in;
      adv_ff <= adv_in;  s_ff <= s_in;  neg_ff <= neg_in;  tabx_ff <= tabx_in;
      m_ff <= m_in;  measn_ff <= measn_in;  rep_ff <= rep_in;
      res_x_ff <= res_x_in;  res_y_ff <= res_y_in;  res_u_ff <= res_u_in;
      res_v_ff <= res_v_in;
      dvd_ff <= dvd_in;  rem_ff <= rem_in;  dvs_ff <= dvs_in;  cnt_ff <= cnt_in;
      out_d_ff <= out_d_in;  out_u_ff <= out_u_in;  out_l_ff <= out_l_in;
   end

endmodule
